@@ rtl/toroidal_wrap_billboard_basis_macros.svh @@
`ifndef TOROIDAL_WRAP_BILLBOARD_BASIS_MACROS_SVH
`define TOROIDAL_WRAP_BILLBOARD_BASIS_MACROS_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define TBW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbw check failed");

// Next-cycle implication, checked on the block clock outside reset.
`define TBW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbw check failed");

`endif

@@ rtl/tbw_pkg.sv @@
package tbw_pkg;

   localparam int CFG_W      = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int NORM_W     = 30;
   localparam int ROOT_STEPS = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CAM_OFS_Y = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_OFS_Z = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HALF_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HALF_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HALF_Z = 3'd4;

   // Cycles through one normalizer: five front stages, the root stages,
   // the divider load stage, two quotient bits per stage, the output stage.
   function automatic int tbw_unit_lat(input int frac);
      return 5 + ROOT_STEPS / 2 + 1 + (frac + 3) / 2 + 1;
   endfunction

endpackage

@@ rtl/toroidal_wrap_billboard_basis.sv @@
// Channel   Handshake              Beat
// req_*     start / busy           star and ship position, Q16.16
// rsp_*     rsp_valid (strobe)     right, up, facing in Q2.14, wrapped position
// csr_*     csr_valid / csr_ready  register index and write data
//
// One beat is taken every clock; busy stays low and csr_ready stays high.
// A beat passes through the input, wrap and camera stages, the root extraction
// and division stages of the two normalizers, and the result stages. Reset is
// synchronous and clears the valid bits and the configuration registers to
// their defaults. The receiver cannot stall, so nothing waits.
`include "toroidal_wrap_billboard_basis_macros.svh"

module toroidal_wrap_billboard_basis #(
   parameter int POS_FRAC_BITS   = 16,
   parameter int BASIS_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_star_px,
   input  logic signed [31:0]                req_star_py,
   input  logic signed [31:0]                req_star_pz,
   input  logic signed [31:0]                req_ship_px,
   input  logic signed [31:0]                req_ship_py,
   input  logic signed [31:0]                req_ship_pz,
   output logic                              rsp_valid,
   output logic signed [15:0]                rsp_right_x,
   output logic signed [15:0]                rsp_right_y,
   output logic signed [15:0]                rsp_right_z,
   output logic signed [15:0]                rsp_upward_x,
   output logic signed [15:0]                rsp_upward_y,
   output logic signed [15:0]                rsp_upward_z,
   output logic signed [15:0]                rsp_facing_x,
   output logic signed [15:0]                rsp_facing_y,
   output logic signed [15:0]                rsp_facing_z,
   output logic signed [31:0]                rsp_wrapped_x,
   output logic signed [31:0]                rsp_wrapped_y,
   output logic signed [31:0]                rsp_wrapped_z,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tbw_pkg::CFG_W-1:0]         csr_wdata
);
   import tbw_pkg::*;

   localparam int FW      = BASIS_FRAC_BITS + 2;
   localparam int DW      = 35;
   localparam int PW      = 2 * FW + 2;
   localparam int LW      = 2 * FW + 1;
   localparam int MW      = 2 * FW;
   localparam int SWA     = 96;
   localparam int SWB     = 1 + 3 * FW + 96;
   localparam int LU      = tbw_unit_lat(BASIS_FRAC_BITS);
   localparam int TOT_LAT = 7 + 2 * LU;

   localparam logic [CFG_W-1:0] RST_CAM_Y  = CFG_W'(longint'(32) << POS_FRAC_BITS);
   localparam logic [CFG_W-1:0] RST_CAM_Z  = CFG_W'(-(longint'(52) << POS_FRAC_BITS));
   localparam logic [CFG_W-1:0] RST_HALF_X = CFG_W'(longint'(180) << POS_FRAC_BITS);
   localparam logic [CFG_W-1:0] RST_HALF_Y = CFG_W'(longint'(90) << POS_FRAC_BITS);
   localparam logic [CFG_W-1:0] RST_HALF_Z = CFG_W'(longint'(180) << POS_FRAC_BITS);

   localparam longint THR = (longint'(1) << (2 * BASIS_FRAC_BITS)) / 1000000;
   localparam logic signed [FW-1:0] ONE_Q  = FW'(longint'(1) << BASIS_FRAC_BITS);
   localparam logic signed [PW-1:0] ONE_W  = PW'(longint'(1) << BASIS_FRAC_BITS);
   localparam logic signed [PW-1:0] HALF_W = PW'(longint'(1) << (BASIS_FRAC_BITS - 1));

   // Configuration registers.
   logic [CFG_W-1:0] cam_ofs_y_ff, cam_ofs_z_ff;
   logic [CFG_W-1:0] box_half_x_ff, box_half_y_ff, box_half_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ofs_y_ff  <= RST_CAM_Y;
         cam_ofs_z_ff  <= RST_CAM_Z;
         box_half_x_ff <= RST_HALF_X;
         box_half_y_ff <= RST_HALF_Y;
         box_half_z_ff <= RST_HALF_Z;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAM_OFS_Y: cam_ofs_y_ff <= csr_wdata;
            CSR_CAM_OFS_Z: cam_ofs_z_ff <= csr_wdata;
            CSR_BOX_HALF_X: box_half_x_ff <= csr_wdata;
            CSR_BOX_HALF_Y: box_half_y_ff <= csr_wdata;
            CSR_BOX_HALF_Z: box_half_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic [2:0][CFG_W-1:0] half_w;
   assign half_w = {box_half_z_ff, box_half_y_ff, box_half_x_ff};

   // Stage 0: input register.
   logic             s0_vld_ff;
   logic [2:0][31:0] star_ff, ship_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      if (start && !busy) begin
         star_ff <= {req_star_pz, req_star_py, req_star_px};
         ship_ff <= {req_ship_pz, req_ship_py, req_ship_px};
      end
   end

   // Stage 1: offset, first wrap toward the box.
   logic                    s1_vld_ff;
   logic signed [DW-1:0]    d1_ff [3];
   logic signed [DW-1:0]    d1_in [3];
   logic signed [DW-1:0]    d0 [3];
   logic signed [DW-1:0]    hh [3];
   logic [2:0][31:0]        ship1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hh[i]    = $signed(DW'(half_w[i]));
         d0[i]    = DW'($signed(star_ff[i])) - DW'($signed(ship_ff[i]));
         d1_in[i] = (d0[i] > hh[i]) ? (d0[i] - hh[i] - hh[i]) : d0[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      d1_ff    <= d1_in;
      ship1_ff <= ship_ff;
   end

   // Stage 2: second wrap, wrapped position saturated to 32 bits.
   logic                    s2_vld_ff;
   logic [2:0][31:0]        w2_ff, w2_in, ship2_ff;
   logic signed [DW-1:0]    d2 [3];
   logic signed [DW-1:0]    ws [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d2[i] = (d1_ff[i] < -hh[i]) ? (d1_ff[i] + hh[i] + hh[i]) : d1_ff[i];
         ws[i] = DW'($signed(ship1_ff[i])) + d2[i];
         if (ws[i] > DW'(64'sh7FFF_FFFF)) begin
            w2_in[i] = 32'h7FFF_FFFF;
         end else if (ws[i] < -DW'(64'sh8000_0000)) begin
            w2_in[i] = 32'h8000_0000;
         end else begin
            w2_in[i] = ws[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      w2_ff    <= w2_in;
      ship2_ff <= ship1_ff;
   end

   // Stage 3: vector from the wrapped star toward the camera.
   logic                  s3_vld_ff;
   logic [2:0][DW-1:0]    tc_ff, tc_in;
   logic [2:0][31:0]      w3_ff;

   always_comb begin
      tc_in[0] = DW'($signed(ship2_ff[0])) - DW'($signed(w2_ff[0]));
      tc_in[1] = DW'($signed(ship2_ff[1])) + DW'($signed(cam_ofs_y_ff))
                 - DW'($signed(w2_ff[1]));
      tc_in[2] = DW'($signed(ship2_ff[2])) + DW'($signed(cam_ofs_z_ff))
                 - DW'($signed(w2_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      tc_ff <= tc_in;
      w3_ff <= w2_ff;
   end

   logic                  fa_vld;
   logic [2:0][FW-1:0]    fa_vec;
   logic [SWA-1:0]        fa_side;

   tbw_unit #(.IW(DW), .FRAC(BASIS_FRAC_BITS), .SW(SWA)) u_facing (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .in_vec    (tc_ff),
      .in_side   (w3_ff),
      .out_valid (fa_vld),
      .out_vec   (fa_vec),
      .out_side  (fa_side)
   );

   // Stage 4: degenerate test and the unnormalized right vector.
   logic                  s4_vld_ff;
   logic                  deg_ff, deg_in;
   logic [2:0][FW:0]      rv_ff, rv_in;
   logic [2:0][FW-1:0]    f4_ff;
   logic [95:0]           w4_ff;
   logic [2*FW:0]         rl2;
   logic signed [LW-1:0]  fx_e, fz_e;

   always_comb begin
      fx_e     = LW'($signed(fa_vec[0]));
      fz_e     = LW'($signed(fa_vec[2]));
      rl2      = fx_e * fx_e + fz_e * fz_e;
      deg_in   = (rl2 <= (2 * FW + 1)'(THR));
      rv_in[0] = (FW + 1)'($signed(fa_vec[2]));
      rv_in[1] = '0;
      rv_in[2] = -(FW + 1)'($signed(fa_vec[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= fa_vld;
      end
      deg_ff <= deg_in;
      rv_ff  <= rv_in;
      f4_ff  <= fa_vec;
      w4_ff  <= fa_side;
   end

   logic                  rb_vld;
   logic [2:0][FW-1:0]    rb_vec;
   logic [SWB-1:0]        rb_side;

   tbw_unit #(.IW(FW + 1), .FRAC(BASIS_FRAC_BITS), .SW(SWB)) u_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_vec    (rv_ff),
      .in_side   ({deg_ff, f4_ff, w4_ff}),
      .out_valid (rb_vld),
      .out_vec   (rb_vec),
      .out_side  (rb_side)
   );

   // Stage 5: pick the right axis and form the cross product terms.
   logic                   rb_deg;
   logic [2:0][FW-1:0]     rb_f;
   logic [95:0]            rb_w;
   logic signed [FW-1:0]   r0_in, r2_in;
   logic signed [MW-1:0]   fe [3];
   logic signed [MW-1:0]   r0_e, r2_e;
   logic signed [MW-1:0]   pr [4];
   logic                   s5_vld_ff;
   logic signed [FW-1:0]   s5_r_ff [3];
   logic signed [PW-1:0]   p_ff [4];
   logic signed [PW-1:0]   p_in [4];
   logic [2:0][FW-1:0]     f5_ff;
   logic [95:0]            w5_ff;

   assign {rb_deg, rb_f, rb_w} = rb_side;

   always_comb begin
      r0_in = rb_deg ? ONE_Q : $signed(rb_vec[0]);
      r2_in = rb_deg ? '0 : $signed(rb_vec[2]);
      for (int i = 0; i < 3; i++) begin
         fe[i] = MW'($signed(rb_f[i]));
      end
      r0_e    = MW'(r0_in);
      r2_e    = MW'(r2_in);
      pr[0]   = fe[1] * r2_e;
      pr[1]   = fe[2] * r0_e;
      pr[2]   = fe[0] * r2_e;
      pr[3]   = fe[1] * r0_e;
      p_in[0] = PW'(pr[0]);
      p_in[1] = PW'(pr[1]);
      p_in[2] = PW'(pr[2]);
      p_in[3] = PW'(pr[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= rb_vld;
      end
      s5_r_ff[0] <= r0_in;
      s5_r_ff[1] <= '0;
      s5_r_ff[2] <= r2_in;
      p_ff       <= p_in;
      f5_ff      <= rb_f;
      w5_ff      <= rb_w;
   end

   // Round half up to the basis format and clamp to one.
   function automatic logic signed [FW-1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      logic signed [PW-1:0] t;
      s = p + HALF_W;
      t = s >>> BASIS_FRAC_BITS;
      if (t > ONE_W) begin
         t = ONE_W;
      end else if (t < -ONE_W) begin
         t = -ONE_W;
      end
      return FW'(t);
   endfunction

   // Stage 6: up axis and the result register.
   logic                 s6_vld_ff;
   logic signed [15:0]   o_right_ff [3];
   logic signed [15:0]   o_up_ff [3];
   logic signed [15:0]   o_face_ff [3];
   logic [2:0][31:0]     o_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         o_right_ff[i] <= 16'(s5_r_ff[i]);
         o_face_ff[i]  <= 16'($signed(f5_ff[i]));
      end
      o_up_ff[0] <= 16'(rnd(p_ff[0]));
      o_up_ff[1] <= 16'(rnd(p_ff[1] - p_ff[2]));
      o_up_ff[2] <= 16'(rnd(-p_ff[3]));
      o_w_ff     <= w5_ff;
   end

   assign rsp_valid     = s6_vld_ff;
   assign rsp_right_x   = o_right_ff[0];
   assign rsp_right_y   = o_right_ff[1];
   assign rsp_right_z   = o_right_ff[2];
   assign rsp_upward_x  = o_up_ff[0];
   assign rsp_upward_y  = o_up_ff[1];
   assign rsp_upward_z  = o_up_ff[2];
   assign rsp_facing_x  = o_face_ff[0];
   assign rsp_facing_y  = o_face_ff[1];
   assign rsp_facing_z  = o_face_ff[2];
   assign rsp_wrapped_x = o_w_ff[0];
   assign rsp_wrapped_y = o_w_ff[1];
   assign rsp_wrapped_z = o_w_ff[2];

   // A valid result always has an accepted beat behind it.
   `TBW_ASSERT_IMP(a_resp_latency, rsp_valid, $past(start && !busy, TOT_LAT))
   // The chosen right axis is never the null vector.
   `TBW_ASSERT_IMP(a_right_nonzero, s5_vld_ff, s5_r_ff[0] != '0 || s5_r_ff[2] != '0)
   // A register write lands on the next clock.
   `TBW_ASSERT_NEXT(a_csr_write, csr_valid && csr_ready && csr_index == CSR_BOX_HALF_X,
                    box_half_x_ff == $past(csr_wdata))

endmodule

@@ rtl/tbw_unit.sv @@
module tbw_unit #(
   parameter int IW   = 35,
   parameter int FRAC = 14,
   parameter int SW   = 96
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0][IW-1:0]    in_vec,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [2:0][FRAC+1:0]  out_vec,
   output logic [SW-1:0]         out_side
);
   import tbw_pkg::*;

   localparam int QW  = FRAC + 2;
   localparam int RW  = FRAC + 33;
   localparam int ND  = (QW + 1) / 2;
   localparam int NSQ = ROOT_STEPS / 2;
   localparam int XW  = IW + NORM_W;
   localparam int AW  = $clog2(XW);

   typedef struct packed {
      logic [2:0]              neg;
      logic                    zero;
      logic [2:0][NORM_W-1:0]  m;
      logic [SW-1:0]           side;
   } com_type;

   typedef struct packed {
      com_type      c;
      logic [63:0]  x;
      logic [63:0]  r;
   } sqs_type;

   typedef struct packed {
      com_type              c;
      logic [30:0]          len;
      logic [2:0][RW-1:0]   rem;
      logic [2:0][QW-1:0]   q;
   } dvs_type;

   // Stage 1: magnitudes and the largest of them.
   logic                 s1_vld_ff;
   logic [2:0]           s1_neg_ff, s1_neg_in;
   logic [2:0][IW-1:0]   s1_mag_ff, s1_mag_in;
   logic [IW-1:0]        s1_mx_ff, s1_mx_in;
   logic [SW-1:0]        s1_side_ff;

   always_comb begin
      s1_mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         s1_neg_in[i] = in_vec[i][IW-1];
         s1_mag_in[i] = s1_neg_in[i] ? (~in_vec[i] + IW'(1)) : in_vec[i];
         if (s1_mag_in[i] > s1_mx_in) begin
            s1_mx_in = s1_mag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
      end
      s1_neg_ff  <= s1_neg_in;
      s1_mag_ff  <= s1_mag_in;
      s1_mx_ff   <= s1_mx_in;
      s1_side_ff <= in_side;
   end

   // Stage 2: leading one of the largest magnitude gives the shift.
   logic                 s2_vld_ff;
   logic [2:0]           s2_neg_ff;
   logic [2:0][IW-1:0]   s2_mag_ff;
   logic                 s2_zero_ff, s2_zero_in;
   logic                 s2_right_ff, s2_right_in;
   logic [AW-1:0]        s2_amt_ff, s2_amt_in;
   logic [AW-1:0]        s2_pos;
   logic [SW-1:0]        s2_side_ff;

   always_comb begin
      s2_pos = '0;
      for (int b = 0; b < IW; b++) begin
         if (s1_mx_ff[b]) begin
            s2_pos = AW'(b);
         end
      end
      s2_zero_in  = (s1_mx_ff == '0);
      s2_right_in = (s2_pos > AW'(NORM_W - 1));
      s2_amt_in   = s2_right_in ? (s2_pos - AW'(NORM_W - 1)) : (AW'(NORM_W - 1) - s2_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_neg_ff   <= s1_neg_ff;
      s2_mag_ff   <= s1_mag_ff;
      s2_zero_ff  <= s2_zero_in;
      s2_right_ff <= s2_right_in;
      s2_amt_ff   <= s2_amt_in;
      s2_side_ff  <= s1_side_ff;
   end

   // Stage 3: bring the largest magnitude into [2^29, 2^30).
   logic     s3_vld_ff;
   com_type  s3_ff, s3_in;
   logic [XW-1:0] s3_ext;

   always_comb begin
      s3_in.neg  = s2_neg_ff;
      s3_in.zero = s2_zero_ff;
      s3_in.side = s2_side_ff;
      s3_ext     = '0;
      for (int i = 0; i < 3; i++) begin
         s3_ext = s2_right_ff ? (XW'(s2_mag_ff[i]) >> s2_amt_ff)
                              : (XW'(s2_mag_ff[i]) << s2_amt_ff);
         s3_in.m[i] = s3_ext[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_ff <= s3_in;
   end

   // Stage 4: squares.
   logic                      s4_vld_ff;
   com_type                   s4_ff;
   logic [2:0][2*NORM_W-1:0]  s4_sq_ff, s4_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_sq_in[i] = s3_ff.m[i] * s3_ff.m[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_ff    <= s3_ff;
      s4_sq_ff <= s4_sq_in;
   end

   // Stage 5 loads the root extraction with the sum of squares.
   logic     sq_vld_ff [NSQ+1];
   sqs_type  sq_ff [NSQ+1];
   sqs_type  sq_load;

   always_comb begin
      sq_load.c = s4_ff;
      sq_load.x = 64'(s4_sq_ff[0]) + 64'(s4_sq_ff[1]) + 64'(s4_sq_ff[2]);
      sq_load.r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s4_vld_ff;
      end
      sq_ff[0] <= sq_load;
   end

   // Floor square root, two result bits per stage.
   for (genvar j = 0; j < NSQ; j++) begin : g_root
      sqs_type      nx;
      logic [63:0]  bw;

      always_comb begin
         nx = sq_ff[j];
         bw = '0;
         for (int t = 0; t < 2; t++) begin
            bw = 64'(1) << (62 - 2 * (2 * j + t));
            if (nx.x >= nx.r + bw) begin
               nx.x = nx.x - (nx.r + bw);
               nx.r = (nx.r >> 1) + bw;
            end else begin
               nx.r = nx.r >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j+1] <= 1'b0;
         end else begin
            sq_vld_ff[j+1] <= sq_vld_ff[j];
         end
         sq_ff[j+1] <= nx;
      end
   end

   // Divider load: numerator is the magnitude scaled up plus half the length.
   logic     dv_vld_ff [ND+1];
   dvs_type  dv_ff [ND+1];
   dvs_type  dv_load;

   always_comb begin
      dv_load.c   = sq_ff[NSQ].c;
      dv_load.len = sq_ff[NSQ].r[30:0];
      dv_load.q   = '0;
      for (int i = 0; i < 3; i++) begin
         dv_load.rem[i] = (RW'(sq_ff[NSQ].c.m[i]) << FRAC) + RW'(dv_load.len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[NSQ];
      end
      dv_ff[0] <= dv_load;
   end

   // Restoring division, two quotient bits per stage, three lanes.
   for (genvar j = 0; j < ND; j++) begin : g_div
      dvs_type        nx;
      logic [RW-1:0]  dsh;
      int             b;

      always_comb begin
         nx  = dv_ff[j];
         dsh = '0;
         b   = 0;
         for (int t = 0; t < 2; t++) begin
            b = QW - 1 - 2 * j - t;
            if (b >= 0) begin
               dsh = RW'(nx.len) << b;
               for (int i = 0; i < 3; i++) begin
                  if (nx.rem[i] >= dsh) begin
                     nx.rem[i]  = nx.rem[i] - dsh;
                     nx.q[i][b] = 1'b1;
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         dv_ff[j+1] <= nx;
      end
   end

   // Output: clamp to 1.0, put the sign back, and give zero for a zero vector.
   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC;

   logic                 out_vld_ff;
   logic [2:0][QW-1:0]   out_vec_ff, out_vec_in;
   logic [SW-1:0]        out_side_ff;
   logic [QW-1:0]        qc;

   always_comb begin
      qc = '0;
      for (int i = 0; i < 3; i++) begin
         qc = (dv_ff[ND].q[i] > ONE_Q) ? ONE_Q : dv_ff[ND].q[i];
         if (dv_ff[ND].c.zero) begin
            out_vec_in[i] = '0;
         end else if (dv_ff[ND].c.neg[i]) begin
            out_vec_in[i] = ~qc + QW'(1);
         end else begin
            out_vec_in[i] = qc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[ND];
      end
      out_vec_ff  <= out_vec_in;
      out_side_ff <= dv_ff[ND].c.side;
   end

   assign out_valid = out_vld_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule
